// ----- sv/buddy_block_allocator_core_defines.svh -----
// assertion macros for the buddy block allocator core
// expects aclk and aresetn in the scope of each use
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define BBA_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// consequence must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- sv/bba_pkg.sv -----
// shared constants, types and helper functions for the buddy allocator
// no dependencies
package bba_pkg;

    localparam int SIZE_W = 17;
    localparam int OFF_W  = 16;
    localparam int LVL_W  = 5;
    localparam int WORD_W = 32;

    typedef logic [LVL_W-1:0]  lvl_t;
    typedef logic [SIZE_W-1:0] cnt_t;

    localparam cnt_t CNT_MAX   = 17'h1FFFF;
    localparam lvl_t TOP_LEVEL = 5'd16;

    // command codes carried on s_tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_HEAP    = 2'd0;
    localparam logic [1:0] CFG_MIN_LVL = 2'd1;
    localparam logic [1:0] CFG_MAX_LVL = 2'd2;

    // position of the highest set bit, zero for zero
    function automatic lvl_t floor_log2(input logic [SIZE_W-1:0] v);
        lvl_t r;
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    // position of the lowest set bit of a memory word
    function automatic logic [4:0] first_set(input logic [WORD_W-1:0] w);
        logic [4:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[SIZE_W-1:0];
    endfunction

    function automatic cnt_t sat_sub(input cnt_t a, input cnt_t b);
        return (b > a) ? '0 : a - b;
    endfunction

endpackage

// ----- sv/buddy_block_allocator_core.sv -----
// buddy block allocator core: free bitmap in one word memory, level counters
// depends on bba_pkg and buddy_block_allocator_core_defines.svh
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | tuser: cmd; tdata: req_size, block_offset
//  m_       | out       | tuser: ok; tdata: result_offset, frag_total, free_total
//  cfg_     | in        | cfg_index, cfg_wr_data (write only)
//
// allocate: walk up the levels skipped, scan the level's bitmap words (up to
// 2^(11-level)), then split; free: check the block, merge and climb, then set it.
// each flag update is a read-modify-write of one 32-bit word of the bitmap memory.
// after reset or any in-range config write the bitmap is cleared word by word
// (2^(12-MIN_BLOCK_LOG2) words, 256 by default), then carved block by block;
// no transfer is taken meanwhile. a result waiting on m_ does not stop the
// next transfer on s_, only the following completion.
`include "buddy_block_allocator_core_defines.svh"

module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int HEAP_MAX_BYTES = 65536,
    parameter int MIN_BLOCK_LOG2 = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // req_size[16:0], block_offset[32:17]
    input  logic        s_tuser,     // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // result_offset[15:0], frag_total[32:16],
                                     // free_total[49:33]
    output logic        m_tuser,     // ok[0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wr_data
);

    localparam int DEPTH    = 1 << (17 - MIN_BLOCK_LOG2);
    localparam int IW       = 17 - MIN_BLOCK_LOG2;
    localparam int NW       = (DEPTH >= WORD_W) ? DEPTH / WORD_W : 1;
    localparam int AW       = (NW > 1) ? $clog2(NW) : 1;
    localparam int NL       = 17 - MIN_BLOCK_LOG2;
    localparam int LW       = $clog2(NL);
    localparam int CW       = 17 - MIN_BLOCK_LOG2;
    localparam int HEAP_CAP = (HEAP_MAX_BYTES < 65536) ? HEAP_MAX_BYTES : 65536;
    localparam lvl_t MIN_LVL = LVL_W'(MIN_BLOCK_LOG2);

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_CRV    = 4'd1;
    localparam logic [3:0] ST_CRV_W  = 4'd2;
    localparam logic [3:0] ST_IDLE   = 4'd3;
    localparam logic [3:0] ST_A_LVL  = 4'd4;
    localparam logic [3:0] ST_A_SCAN = 4'd5;
    localparam logic [3:0] ST_A_FWR  = 4'd6;
    localparam logic [3:0] ST_A_SRD  = 4'd7;
    localparam logic [3:0] ST_A_SWR  = 4'd8;
    localparam logic [3:0] ST_F_RD   = 4'd9;
    localparam logic [3:0] ST_F_OWN  = 4'd10;
    localparam logic [3:0] ST_F_BRD  = 4'd11;
    localparam logic [3:0] ST_F_BCHK = 4'd12;
    localparam logic [3:0] ST_F_SRD  = 4'd13;
    localparam logic [3:0] ST_F_SWR  = 4'd14;
    localparam logic [3:0] ST_FIN    = 4'd15;

    // bit index of a (level, offset) flag: levels stacked from MIN upward
    function automatic logic [IW-1:0] slot_idx(input lvl_t l, input logic [15:0] off);
        logic [17:0] b;
        b = 18'(DEPTH) - (18'(1) << (5'd17 - l)) + 18'(off >> l);
        return b[IW-1:0];
    endfunction

    function automatic logic [AW-1:0] word_of(input logic [IW-1:0] idx);
        return AW'(idx >> 5);
    endfunction

    function automatic logic [LW-1:0] cidx(input lvl_t l);
        return LW'(l - MIN_LVL);
    endfunction

    // registers
    logic [3:0]    state_reg, state_next;
    logic [16:0]   heap_bytes_reg, heap_bytes_next;
    lvl_t          min_level_reg, min_level_next;
    lvl_t          max_level_reg, max_level_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [16:0]   rem_reg, rem_next;
    logic [16:0]   coff_reg, coff_next;
    logic [16:0]   carved_end_reg, carved_end_next;
    logic          cmd_reg, cmd_next;
    logic [16:0]   size_reg, size_next;
    lvl_t          lvl_reg, lvl_next;
    lvl_t          cur_l_reg, cur_l_next;
    logic [15:0]   cur_off_reg, cur_off_next;
    logic [IW-1:0] acc_idx_reg, acc_idx_next;
    lvl_t          acc_lvl_reg, acc_lvl_next;
    logic [AW-1:0] scan_wa_reg, scan_wa_next;
    logic [AW-1:0] scan_end_reg, scan_end_next;
    logic          ok_reg, ok_next;
    logic [15:0]   res_off_reg, res_off_next;
    cnt_t          frag_reg, frag_next;
    cnt_t          free_reg, free_next;
    logic          m_tvalid_reg;
    logic          m_ok_reg;
    logic [15:0]   m_off_reg;
    cnt_t          m_frag_reg;
    cnt_t          m_free_reg;
    logic [CW-1:0] cnt_reg [NL];
    logic [WORD_W-1:0] rd_data_reg;

    // bitmap memory
    logic [WORD_W-1:0] mem [NW];
    logic              mem_re, mem_we;
    logic [AW-1:0]     mem_raddr, mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic wr_bit_en, wr_bit_val, cnt_clear, out_load;

    // effective configuration
    lvl_t        eff_min, eff_max;
    logic [16:0] heap_init;

    always_comb begin
        eff_min = min_level_reg;
        if (eff_min < MIN_LVL) eff_min = MIN_LVL;
        if (eff_min > TOP_LEVEL) eff_min = TOP_LEVEL;
        eff_max = max_level_reg;
        if (eff_max > TOP_LEVEL) eff_max = TOP_LEVEL;
        if (eff_max < eff_min) eff_max = eff_min;
        heap_init = (heap_bytes_reg > 17'(HEAP_CAP)) ? 17'(HEAP_CAP) : heap_bytes_reg;
    end

    // input fields and request level
    logic        in_cmd;
    logic [16:0] in_size;
    logic [15:0] in_boff;
    lvl_t        ceil_l, req_lvl;
    logic [16:0] req_pow;
    logic        in_aligned, in_heap;

    assign in_cmd  = s_tuser;
    assign in_size = s_tdata[16:0];
    assign in_boff = s_tdata[32:17];

    always_comb begin
        ceil_l     = (in_size <= 17'd1) ? '0 : floor_log2(in_size - 17'd1) + 5'd1;
        req_lvl    = (ceil_l < eff_min) ? eff_min : ceil_l;
        req_pow    = 17'(1) << req_lvl;
        in_aligned = ((17'(in_boff) & (req_pow - 17'd1)) == '0);
        in_heap    = (18'(in_boff) + 18'(req_pow)) <= 18'(carved_end_reg);
    end

    // carve step level
    lvl_t carve_l;
    always_comb begin
        carve_l = floor_log2(rem_reg);
        if (carve_l > eff_max) carve_l = eff_max;
    end

    // bitmap addresses used by the sequencer
    logic [IW-1:0] carve_idx, cur_base, own_idx, bud_idx, split_idx, found_idx, rel_idx;
    lvl_t          split_l;
    logic [12:0]   lvl_words;
    logic [WORD_W-1:0] scan_mask, scan_hit;
    logic [17:0]   lvl_bits;
    logic [4:0]    hit_pos;

    always_comb begin
        carve_idx = slot_idx(carve_l, coff_reg[15:0]);
        cur_base  = slot_idx(cur_l_reg, '0);
        own_idx   = slot_idx(cur_l_reg, cur_off_reg);
        bud_idx   = slot_idx(cur_l_reg, cur_off_reg ^ (16'(1) << cur_l_reg));
        split_l   = cur_l_reg - 5'd1;
        split_idx = slot_idx(split_l, res_off_reg + (16'(1) << split_l));
        lvl_words = (cur_l_reg > 5'd11) ? 13'd0 : (13'(1) << (5'd11 - cur_l_reg)) - 13'd1;
        // levels narrower than a word share the top word
        lvl_bits  = 18'(1) << (5'd16 - cur_l_reg);
        if (cur_l_reg > 5'd11) begin
            scan_mask = ((WORD_W'(1) << lvl_bits[4:0]) - WORD_W'(1)) << cur_base[4:0];
        end else begin
            scan_mask = '1;
        end
        scan_hit  = rd_data_reg & scan_mask;
        hit_pos   = first_set(scan_hit);
        found_idx = IW'({scan_wa_reg, hit_pos});
        rel_idx   = found_idx - cur_base;
    end

    // result counters for the completing item
    logic [16:0] fin_pow, fin_slack;
    cnt_t        fin_frag, fin_free;
    always_comb begin
        fin_pow   = 17'(1) << lvl_reg;
        fin_slack = fin_pow - ((size_reg < fin_pow) ? size_reg : fin_pow);
        if (cmd_reg == CMD_ALLOC) begin
            fin_frag = sat_add(frag_reg, fin_slack);
            fin_free = sat_sub(free_reg, fin_pow);
        end else begin
            fin_frag = sat_sub(frag_reg, fin_slack);
            fin_free = sat_add(free_reg, fin_pow);
        end
    end

    logic acc_bit_old;
    assign acc_bit_old = rd_data_reg[acc_idx_reg[4:0]];

    // sequencer
    always_comb begin
        state_next      = state_reg;
        heap_bytes_next = heap_bytes_reg;
        min_level_next  = min_level_reg;
        max_level_next  = max_level_reg;
        clr_addr_next   = clr_addr_reg;
        rem_next        = rem_reg;
        coff_next       = coff_reg;
        carved_end_next = carved_end_reg;
        cmd_next        = cmd_reg;
        size_next       = size_reg;
        lvl_next        = lvl_reg;
        cur_l_next      = cur_l_reg;
        cur_off_next    = cur_off_reg;
        acc_idx_next    = acc_idx_reg;
        acc_lvl_next    = acc_lvl_reg;
        scan_wa_next    = scan_wa_reg;
        scan_end_next   = scan_end_reg;
        ok_next         = ok_reg;
        res_off_next    = res_off_reg;
        frag_next       = frag_reg;
        free_next       = free_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        wr_bit_en       = 1'b0;
        wr_bit_val      = 1'b0;
        cnt_clear       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_CLR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                cnt_clear     = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(NW - 1)) begin
                    state_next = ST_CRV;
                    rem_next   = heap_init;
                    coff_next  = '0;
                end
            end
            ST_CRV: begin
                if (rem_reg > (17'(1) << eff_min)) begin
                    acc_idx_next = carve_idx;
                    acc_lvl_next = carve_l;
                    mem_re       = 1'b1;
                    mem_raddr    = word_of(carve_idx);
                    state_next   = ST_CRV_W;
                end else begin
                    carved_end_next = coff_reg;
                    free_next       = coff_reg;
                    frag_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_CRV_W: begin
                wr_bit_en  = 1'b1;
                wr_bit_val = 1'b1;
                coff_next  = coff_reg + (17'(1) << acc_lvl_reg);
                rem_next   = rem_reg - (17'(1) << acc_lvl_reg);
                state_next = ST_CRV;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    size_next    = in_size;
                    lvl_next     = req_lvl;
                    cur_l_next   = req_lvl;
                    cur_off_next = in_boff;
                    ok_next      = 1'b0;
                    res_off_next = '0;
                    priority if (req_lvl > eff_max) begin
                        state_next = ST_FIN;
                    end else if (in_cmd == CMD_ALLOC) begin
                        state_next = ST_A_LVL;
                    end else if (!in_aligned || !in_heap) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_F_RD;
                    end
                end
            end
            // walk up the levels until one holds a free block
            ST_A_LVL: begin
                if (cur_l_reg > eff_max) begin
                    state_next = ST_FIN;
                end else if (cnt_reg[cidx(cur_l_reg)] != '0) begin
                    mem_re        = 1'b1;
                    mem_raddr     = word_of(cur_base);
                    scan_wa_next  = word_of(cur_base);
                    scan_end_next = word_of(cur_base) + AW'(lvl_words);
                    state_next    = ST_A_SCAN;
                end else begin
                    cur_l_next = cur_l_reg + 5'd1;
                end
            end
            // scan the level's words for the lowest free block
            ST_A_SCAN: begin
                if (scan_hit != '0) begin
                    acc_idx_next = found_idx;
                    acc_lvl_next = cur_l_reg;
                    res_off_next = 16'(32'(rel_idx) << cur_l_reg);
                    state_next   = ST_A_FWR;
                end else if (scan_wa_reg == scan_end_reg) begin
                    state_next = ST_FIN;
                end else begin
                    scan_wa_next = scan_wa_reg + AW'(1);
                    mem_re       = 1'b1;
                    mem_raddr    = scan_wa_reg + AW'(1);
                end
            end
            ST_A_FWR: begin
                wr_bit_en = 1'b1;
                if (cur_l_reg > lvl_reg) begin
                    state_next = ST_A_SRD;
                end else begin
                    ok_next    = 1'b1;
                    state_next = ST_FIN;
                end
            end
            // split: free the upper half one level down
            ST_A_SRD: begin
                cur_l_next   = split_l;
                acc_idx_next = split_idx;
                acc_lvl_next = split_l;
                mem_re       = 1'b1;
                mem_raddr    = word_of(split_idx);
                state_next   = ST_A_SWR;
            end
            ST_A_SWR: begin
                wr_bit_en  = 1'b1;
                wr_bit_val = 1'b1;
                if (cur_l_reg > lvl_reg) begin
                    state_next = ST_A_SRD;
                end else begin
                    ok_next    = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_F_RD: begin
                acc_idx_next = own_idx;
                acc_lvl_next = cur_l_reg;
                mem_re       = 1'b1;
                mem_raddr    = word_of(own_idx);
                state_next   = ST_F_OWN;
            end
            // double free of the exact block is rejected
            ST_F_OWN: begin
                state_next = acc_bit_old ? ST_FIN : ST_F_BRD;
            end
            ST_F_BRD: begin
                if (cur_l_reg < eff_max) begin
                    acc_idx_next = bud_idx;
                    acc_lvl_next = cur_l_reg;
                    mem_re       = 1'b1;
                    mem_raddr    = word_of(bud_idx);
                    state_next   = ST_F_BCHK;
                end else begin
                    state_next = ST_F_SRD;
                end
            end
            // merge with a free buddy and climb
            ST_F_BCHK: begin
                if (acc_bit_old) begin
                    wr_bit_en    = 1'b1;
                    cur_off_next = cur_off_reg & ~(16'(1) << cur_l_reg);
                    cur_l_next   = cur_l_reg + 5'd1;
                    state_next   = ST_F_BRD;
                end else begin
                    state_next = ST_F_SRD;
                end
            end
            ST_F_SRD: begin
                acc_idx_next = own_idx;
                acc_lvl_next = cur_l_reg;
                mem_re       = 1'b1;
                mem_raddr    = word_of(own_idx);
                state_next   = ST_F_SWR;
            end
            ST_F_SWR: begin
                wr_bit_en  = 1'b1;
                wr_bit_val = 1'b1;
                ok_next    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (ok_reg) begin
                        frag_next = fin_frag;
                        free_next = fin_free;
                    end
                end
            end
        endcase

        // single-bit read-modify-write on the word last read into rd_data_reg
        if (wr_bit_en) begin
            mem_we                       = 1'b1;
            mem_waddr                    = word_of(acc_idx_reg);
            mem_wdata                    = rd_data_reg;
            mem_wdata[acc_idx_reg[4:0]]  = wr_bit_val;
        end

        // an in-range configuration write restarts the clear and carve
        if (cfg_wr_en) begin
            priority if (cfg_index == CFG_HEAP) begin
                heap_bytes_next = cfg_wr_data;
                state_next      = ST_CLR;
                clr_addr_next   = '0;
            end else if (cfg_index == CFG_MIN_LVL) begin
                min_level_next = cfg_wr_data[4:0];
                state_next     = ST_CLR;
                clr_addr_next  = '0;
            end else if (cfg_index == CFG_MAX_LVL) begin
                max_level_next = cfg_wr_data[4:0];
                state_next     = ST_CLR;
                clr_addr_next  = '0;
            end else begin
                state_next = state_next;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            heap_bytes_reg <= 17'd65536;
            min_level_reg  <= 5'd4;
            max_level_reg  <= 5'd16;
            clr_addr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            heap_bytes_reg <= heap_bytes_next;
            min_level_reg  <= min_level_next;
            max_level_reg  <= max_level_next;
            clr_addr_reg   <= clr_addr_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        coff_reg       <= coff_next;
        carved_end_reg <= carved_end_next;
        cmd_reg        <= cmd_next;
        size_reg       <= size_next;
        lvl_reg        <= lvl_next;
        cur_l_reg      <= cur_l_next;
        cur_off_reg    <= cur_off_next;
        acc_idx_reg    <= acc_idx_next;
        acc_lvl_reg    <= acc_lvl_next;
        scan_wa_reg    <= scan_wa_next;
        scan_end_reg   <= scan_end_next;
        ok_reg         <= ok_next;
        res_off_reg    <= res_off_next;
        frag_reg       <= frag_next;
        free_reg       <= free_next;
        if (out_load) begin
            m_ok_reg   <= ok_reg;
            m_off_reg  <= res_off_reg;
            m_frag_reg <= frag_next;
            m_free_reg <= free_next;
        end
    end

    // free block count per level, follows every flag that changes
    always_ff @(posedge aclk) begin
        if (cnt_clear) begin
            for (int i = 0; i < NL; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (wr_bit_en && (acc_bit_old != wr_bit_val)) begin
            if (wr_bit_val) begin
                cnt_reg[cidx(acc_lvl_reg)] <= cnt_reg[cidx(acc_lvl_reg)] + CW'(1);
            end else begin
                cnt_reg[cidx(acc_lvl_reg)] <= cnt_reg[cidx(acc_lvl_reg)] - CW'(1);
            end
        end
    end

    // bitmap memory, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {6'b0, m_free_reg, m_frag_reg, m_off_reg};

    // checks
    `BBA_ASSERT_SAME(a_no_rw_overlap, mem_we, !mem_re)
    `BBA_ASSERT_SAME(a_scan_level_nonempty, state_reg == ST_A_SCAN, cnt_reg[cidx(cur_l_reg)] != '0)
    `BBA_ASSERT_NEXT(a_cfg_restarts_carve, cfg_wr_en && cfg_index <= CFG_MAX_LVL, state_reg == ST_CLR)

endmodule
